// ----- rtl/assert_macros.svh -----
// Assertion macros used by the allocator unit.
// Each macro checks a property on the rising edge of clk, with rst held off.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// Size class allocator package
// Shared constants and types for the size class block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  localparam int NUM_CLASSES     = 4;
  localparam int REG_CLASSES     = 4;
  localparam int SLOTS_PER_CLASS = 16;
  localparam int SIZE_BITS       = 32;

  localparam int CLASS_BITS   = $clog2(REG_CLASSES);
  localparam int SLOT_BITS    = $clog2(SLOTS_PER_CLASS);
  localparam int COUNT_BITS   = $clog2(SLOTS_PER_CLASS + 1);
  localparam int ADDR_BITS    = CLASS_BITS + $clog2(SLOTS_PER_CLASS);
  localparam int RING_DEPTH   = REG_CLASSES * SLOTS_PER_CLASS;
  localparam int BLOCKS_W     = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_BASE   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_BASE = CFG_IDX_BITS'(REG_CLASSES);

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_RET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_NOT_AVAIL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/size_class_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Size class block allocator
// Hands out and takes back fixed-size blocks from up to four size classes,
// each class keeping a ring of free slot numbers.
// ----------------------------------------------------------------------------
// A get request is checked against the classes one per cycle by a single size
// comparator. A get with a zero size goes from the transfer straight to the
// result load; otherwise the scan stops at the first class that fits, which
// then goes through a state for the free ring memory read, or at the last
// class when none fits, and the result is loaded. A return passes through the
// transfer, a state that checks the class and slot and writes the ring tail,
// and the load of the result. The block takes one request at a time, but a
// new request may be transferred while the previous result waits on the output.
// Ring entries that were never written since reset or since their class count
// was written read as their own index, tracked by one flag per entry, so no
// clearing pass is needed. Configuration writes are taken whenever reset is
// low and must only be issued while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module size_class_block_allocator_unit
  import sca_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]    cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     func,
  input  wire [SIZE_BITS-1:0]     req_size,
  input  wire [CLASS_BITS-1:0]    ret_class,
  input  wire [SLOT_BITS-1:0]     ret_slot,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              status,
  output logic [CLASS_BITS-1:0]   grant_class,
  output logic [SLOT_BITS-1:0]    grant_slot
);

  state_t state, state_next;

  logic [SIZE_BITS-1:0]  class_size   [REG_CLASSES];
  logic [COUNT_BITS-1:0] class_blocks [REG_CLASSES];
  logic [SLOT_BITS-1:0]  ring_head    [REG_CLASSES];
  logic [COUNT_BITS-1:0] free_count   [REG_CLASSES];
  logic [RING_DEPTH-1:0] ring_vld;

  logic                  func_q;
  logic [SIZE_BITS-1:0]  req_q;
  logic [SLOT_BITS-1:0]  rs_q;
  logic [CLASS_BITS-1:0] cls;
  logic                  rd_vld;
  logic [SLOT_BITS-1:0]  rd_idx;

  status_t               res_status;
  logic [CLASS_BITS-1:0] res_class;

  logic [SIZE_BITS-1:0]  cur_size;
  logic [COUNT_BITS-1:0] cur_blocks;
  logic [SLOT_BITS-1:0]  cur_head;
  logic [COUNT_BITS-1:0] cur_count;
  logic                  fit;
  logic                  cls_last;
  logic                  ret_ok;
  logic [SLOT_BITS-1:0]  head_inc;
  logic [COUNT_BITS-1:0] tail_sum;
  logic [SLOT_BITS-1:0]  tail;

  logic                  in_xfer;
  logic                  out_load;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [SLOT_BITS-1:0]  ram_rdata;

  logic [CLASS_BITS-1:0] cfg_cls;
  logic [BLOCKS_W-1:0]   cfg_blocks;
  logic [COUNT_BITS-1:0] cfg_eff;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  assign cur_size   = class_size[cls];
  assign cur_blocks = class_blocks[cls];
  assign cur_head   = ring_head[cls];
  assign cur_count  = free_count[cls];

  assign fit      = (cur_size >= req_q) && (cur_count != '0);
  assign cls_last = (cls == CLASS_BITS'(NUM_CLASSES - 1));
  assign ret_ok   = ({1'b0, cls} < (CLASS_BITS + 1)'(NUM_CLASSES)) &&
                    ({1'b0, rs_q} < cur_blocks) && (cur_count < cur_blocks);
  assign head_inc = (cur_head == SLOT_BITS'(SLOTS_PER_CLASS - 1)) ? '0
                                                                   : cur_head + SLOT_BITS'(1);
  assign tail_sum = COUNT_BITS'(cur_head) + cur_count;
  assign tail     = (tail_sum >= COUNT_BITS'(SLOTS_PER_CLASS))
                    ? SLOT_BITS'(tail_sum - COUNT_BITS'(SLOTS_PER_CLASS))
                    : SLOT_BITS'(tail_sum);

  assign ram_re    = (state == S_SCAN) && fit;
  assign ram_raddr = {cls, cur_head};
  assign ram_we    = (state == S_CHECK) && ret_ok;
  assign ram_waddr = {cls, tail};

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign cfg_cls    = cfg_index[CLASS_BITS-1:0];
  assign cfg_blocks = cfg_data[BLOCKS_W-1:0];
  assign cfg_eff    = (cfg_blocks > BLOCKS_W'(SLOTS_PER_CLASS))
                      ? COUNT_BITS'(SLOTS_PER_CLASS) : COUNT_BITS'(cfg_blocks);

  sca_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rs_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (func == FUNC_RET) begin
            state_next = S_CHECK;
          end else if (req_size == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (fit) begin
          state_next = S_READ;
        end else if (cls_last) begin
          state_next = S_DONE;
        end
      end
      S_READ:  state_next = S_DONE;
      S_CHECK: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Class registers, ring pointers and free flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < REG_CLASSES; c++) begin
        class_size[c]   <= '0;
        class_blocks[c] <= '0;
        ring_head[c]    <= '0;
        free_count[c]   <= '0;
      end
      ring_vld <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_BLOCKS_BASE) begin
          class_size[cfg_cls] <= cfg_data[SIZE_BITS-1:0];
        end else begin
          class_blocks[cfg_cls] <= cfg_eff;
          ring_head[cfg_cls]    <= '0;
          free_count[cfg_cls]   <= cfg_eff;
          for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
            ring_vld[{cfg_cls, SLOT_BITS'(i)}] <= 1'b0;
          end
        end
      end
      if (ram_re) begin
        ring_head[cls]  <= head_inc;
        free_count[cls] <= cur_count - COUNT_BITS'(1);
      end
      if (ram_we) begin
        free_count[cls]     <= cur_count + COUNT_BITS'(1);
        ring_vld[ram_waddr] <= 1'b1;
      end
    end
  end

  // Request capture, class sequencing and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_q <= func;
      req_q  <= req_size;
      rs_q   <= ret_slot;
      cls    <= (func == FUNC_RET) ? ret_class : '0;
      if (func == FUNC_GET && req_size == '0) begin
        res_status <= ST_BAD_PARAM;
        res_class  <= '0;
        rd_idx     <= '0;
        rd_vld     <= 1'b0;
      end
    end
    case (state)
      S_SCAN: begin
        if (fit) begin
          res_status <= ST_OK;
          res_class  <= cls;
          rd_vld     <= ring_vld[ram_raddr];
          rd_idx     <= cur_head;
        end else if (cls_last) begin
          res_status <= ST_NOT_AVAIL;
          res_class  <= '0;
          rd_vld     <= 1'b0;
          rd_idx     <= '0;
        end else begin
          cls <= cls + CLASS_BITS'(1);
        end
      end
      S_READ: begin
        rd_vld <= 1'b0;
        rd_idx <= rd_vld ? ram_rdata : rd_idx;
      end
      S_CHECK: begin
        res_status <= ret_ok ? ST_OK : ST_BAD_PARAM;
        res_class  <= '0;
        rd_vld     <= 1'b0;
        rd_idx     <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      grant_class <= res_class;
      grant_slot  <= rd_idx;
    end
  end

  `ASSERT_SAME(a_count_bound, state != S_IDLE, free_count[cls] <= class_blocks[cls], "free count above block count")
  `ASSERT_SAME(a_fail_zero, out_valid && status != ST_OK, grant_class == '0 && grant_slot == '0, "grant fields set on a failed result")
  `ASSERT_SAME(a_ram_excl, ram_we, !ram_re, "ring read and write in the same cycle")
  `ASSERT_NEXT(a_one_item, in_xfer, !in_ready, "second request taken while one is in work")
  `ASSERT_SAME(a_ret_no_grant, out_load && func_q == FUNC_RET, res_class == '0 && rd_idx == '0, "grant fields set on a return")

endmodule

`default_nettype wire

// ----- rtl/sca_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
